### design/mqtt_pkg.sv
// ----------------------------------------------------------------------------
// mqtt_pkg
// Shared constants and decode helpers for the MQTT control packet parser.
// ----------------------------------------------------------------------------
package mqtt_pkg;

  // Field tags and parser phases
  localparam logic [4:0] FK_HEADER    = 5'd0;
  localparam logic [4:0] FK_LENGTH    = 5'd1;
  localparam logic [4:0] FK_NAME_LEN  = 5'd2;
  localparam logic [4:0] FK_NAME      = 5'd3;
  localparam logic [4:0] FK_LEVEL     = 5'd4;
  localparam logic [4:0] FK_CFLAGS    = 5'd5;
  localparam logic [4:0] FK_KEEPALIVE = 5'd6;
  localparam logic [4:0] FK_CID_LEN   = 5'd7;
  localparam logic [4:0] FK_CID       = 5'd8;
  localparam logic [4:0] FK_WT_LEN    = 5'd9;
  localparam logic [4:0] FK_WT        = 5'd10;
  localparam logic [4:0] FK_WM_LEN    = 5'd11;
  localparam logic [4:0] FK_WM        = 5'd12;
  localparam logic [4:0] FK_USER_LEN  = 5'd13;
  localparam logic [4:0] FK_USER      = 5'd14;
  localparam logic [4:0] FK_PASS_LEN  = 5'd15;
  localparam logic [4:0] FK_PASS      = 5'd16;
  localparam logic [4:0] FK_TOPIC_LEN = 5'd17;
  localparam logic [4:0] FK_TOPIC     = 5'd18;
  localparam logic [4:0] FK_PKT_ID    = 5'd19;
  localparam logic [4:0] FK_PAYLOAD   = 5'd20;
  localparam logic [4:0] FK_QOS       = 5'd21;
  localparam logic [4:0] FK_SKIP      = 5'd22;
  localparam logic [4:0] PH_FIRST_LEN = 5'd23;

  // Packet types
  localparam logic [3:0] T_CONNECT     = 4'd1;
  localparam logic [3:0] T_PUBLISH     = 4'd3;
  localparam logic [3:0] T_PUBACK      = 4'd4;
  localparam logic [3:0] T_SUBSCRIBE   = 4'd8;
  localparam logic [3:0] T_UNSUBSCRIBE = 4'd10;
  localparam logic [3:0] T_DISCONNECT  = 4'd14;

  // Verdicts
  localparam logic [2:0] ST_BUSY        = 3'd0;
  localparam logic [2:0] ST_OK          = 3'd1;
  localparam logic [2:0] ST_BAD_FLAGS   = 3'd2;
  localparam logic [2:0] ST_MALFORMED   = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  localparam int LEN_BYTES  = 4;
  localparam int DATA_W     = 96;
  localparam int USER_W     = 9;

  function automatic logic is_word(input logic [4:0] ph);
    return ph == FK_NAME_LEN || ph == FK_KEEPALIVE || ph == FK_CID_LEN ||
           ph == FK_WT_LEN || ph == FK_WM_LEN || ph == FK_USER_LEN ||
           ph == FK_PASS_LEN || ph == FK_TOPIC_LEN || ph == FK_PKT_ID ||
           ph == PH_FIRST_LEN;
  endfunction

  // Field byte count loaded on entry to a phase
  function automatic logic [15:0] go_rem(input logic [4:0] ph);
    return is_word(ph) ? 16'd2 : 16'd1;
  endfunction

  function automatic logic supported(input logic [3:0] kind);
    return kind == T_CONNECT || kind == T_PUBLISH || kind == T_PUBACK ||
           kind == T_SUBSCRIBE || kind == T_UNSUBSCRIBE || kind == T_DISCONNECT;
  endfunction

  function automatic logic flags_wrong(input logic [3:0] kind, input logic [3:0] flags);
    if (kind == T_SUBSCRIBE || kind == T_UNSUBSCRIBE) return flags != 4'd2;
    if (kind == T_PUBLISH) return flags[2:1] == 2'd3;
    return 1'b0;
  endfunction

  // Next phase after a field completes
  function automatic logic [4:0] successor(input logic [4:0] ph, input logic [7:0] cfl,
                                           input logic [3:0] kind, input logic [3:0] flags);
    logic [4:0] au;
    logic [4:0] aw;
    au = cfl[6] ? FK_PASS_LEN : FK_SKIP;
    aw = cfl[7] ? FK_USER_LEN : au;
    case (ph)
      FK_NAME:      return FK_LEVEL;
      FK_LEVEL:     return FK_CFLAGS;
      FK_CFLAGS:    return FK_KEEPALIVE;
      FK_KEEPALIVE: return FK_CID_LEN;
      FK_CID:       return cfl[2] ? FK_WT_LEN : aw;
      FK_WT:        return FK_WM_LEN;
      FK_WM:        return aw;
      FK_USER:      return au;
      FK_PASS:      return FK_SKIP;
      FK_TOPIC: begin
        if (kind == T_PUBLISH) return (flags[2:1] != 2'd0) ? FK_PKT_ID : FK_PAYLOAD;
        if (kind == T_SUBSCRIBE) return FK_QOS;
        return FK_TOPIC_LEN;
      end
      FK_QOS:       return FK_TOPIC_LEN;
      FK_PKT_ID: begin
        if (kind == T_PUBLISH) return FK_PAYLOAD;
        if (kind == T_PUBACK) return FK_SKIP;
        return PH_FIRST_LEN;
      end
      default:      return FK_SKIP;
    endcase
  endfunction

  // Completing this field advances the filter index
  function automatic logic bumps(input logic [4:0] ph, input logic [3:0] kind);
    return ph == FK_QOS ||
           (ph == FK_TOPIC && kind != T_PUBLISH && kind != T_SUBSCRIBE);
  endfunction

  function automatic logic [2:0] verdict(input logic [4:0] ph, input logic err,
                                         input logic [3:0] kind, input logic [3:0] flags,
                                         input logic [15:0] frem);
    if (err) begin
      if (!supported(kind)) return ST_UNSUPPORTED;
      if (flags_wrong(kind, flags)) return ST_BAD_FLAGS;
      return ST_MALFORMED;
    end
    if (ph == FK_SKIP) return ST_OK;
    if (kind == T_PUBLISH && ph == FK_PAYLOAD) return ST_OK;
    if ((kind == T_SUBSCRIBE || kind == T_UNSUBSCRIBE) &&
        ph == FK_TOPIC_LEN && frem == 16'd2) return ST_OK;
    return ST_MALFORMED;
  endfunction

endpackage

### design/mqtt_control_packet_parser.sv
// ----------------------------------------------------------------------------
// mqtt_control_packet_parser
// Tags MQTT bytes with packet type and field, one byte a cycle barring stalls.
// ----------------------------------------------------------------------------
// The result word is registered, valid the cycle after its input word is taken.
// Throughput: one byte per cycle barring stalls; state update is a single pass.
// The output register frees in_tready whenever out is empty or being taken.
// Reset (rst_n low, synchronous) returns the parser to waiting for a header.
module mqtt_control_packet_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,  // [7:0] rx_byte
  input  logic                           in_tuser,  // [0] resync
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] field_byte, [23:8] field_word, [24] word_valid, [32:25] filter_index,
  // [60:33] body_length, [88:61] body_left, [91:89] status, [95:92] zero
  output logic [mqtt_pkg::DATA_W-1:0]    out_tdata,
  // [3:0] packet_kind, [8:4] field_kind
  output logic [mqtt_pkg::USER_W-1:0]    out_tuser,
  output logic                           out_tlast  // packet_end
);
  import mqtt_pkg::*;

  logic [4:0]  ph_r, ph_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [27:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [27:0] br_r, br_nxt;
  logic [15:0] frem_r, frem_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [7:0]  cfl_r, cfl_nxt;
  logic [7:0]  filt_r, filt_nxt;
  logic        err_r, err_nxt;

  logic        ovalid_r;
  logic [DATA_W-1:0] odata_r;
  logic [USER_W-1:0] ouser_r;
  logic        olast_r;

  logic        accept;
  logic [7:0]  b;
  logic [4:0]  fk;
  logic [7:0]  fb;
  logic [15:0] word;
  logic        wv;
  logic        pend;
  logic [2:0]  st;
  logic [7:0]  idx;
  logic [27:0] addend;
  logic [15:0] wtmp;
  logic [15:0] fdec;
  logic [4:0]  sp;
  logic [4:0]  nx;
  logic        bump;

  assign b         = in_tdata;
  assign in_tready = !ovalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Decode one byte against the current parser state
  always_comb begin
    ph_nxt = ph_r; kind_nxt = kind_r; flags_nxt = flags_r; acc_nxt = acc_r;
    cnt_nxt = cnt_r; br_nxt = br_r; frem_nxt = frem_r; hold_nxt = hold_r;
    cfl_nxt = cfl_r; filt_nxt = filt_r; err_nxt = err_r;
    fk = FK_HEADER; fb = b; word = 16'd0; wv = 1'b0; pend = 1'b0; st = ST_BUSY;
    idx = 8'd0; addend = 28'd0; wtmp = {hold_r, b}; fdec = frem_r - 16'd1;
    sp = FK_SKIP; nx = FK_SKIP; bump = 1'b0;
    if (in_tuser || ph_r == FK_HEADER) begin
      kind_nxt = b[7:4]; flags_nxt = b[3:0];
      acc_nxt = 28'd0; cnt_nxt = 2'd0; br_nxt = 28'd0; frem_nxt = 16'd0;
      cfl_nxt = 8'd0; filt_nxt = 8'd0; err_nxt = 1'b0;
      ph_nxt = FK_LENGTH;
    end else if (ph_r == FK_LENGTH) begin
      fk = FK_LENGTH;
      case (cnt_r)
        2'd0:    addend = {21'd0, b[6:0]};
        2'd1:    addend = {14'd0, b[6:0], 7'd0};
        2'd2:    addend = {7'd0, b[6:0], 14'd0};
        default: addend = {b[6:0], 21'd0};
      endcase
      acc_nxt = acc_r + addend;
      if (b[7]) begin
        if ({1'b0, cnt_r} + 3'd1 >= 3'(LEN_BYTES)) begin
          pend = 1'b1; st = ST_MALFORMED; ph_nxt = FK_HEADER;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end else begin
        br_nxt = acc_nxt; filt_nxt = 8'd0; cfl_nxt = 8'd0;
        if (!supported(kind_r) || flags_wrong(kind_r, flags_r) ||
            (kind_r == T_DISCONNECT && flags_r != 4'd0)) begin
          err_nxt = 1'b1; nx = FK_SKIP;
        end else begin
          case (kind_r)
            T_CONNECT:    nx = FK_NAME_LEN;
            T_PUBLISH:    nx = FK_TOPIC_LEN;
            T_DISCONNECT: nx = FK_SKIP;
            default:      nx = FK_PKT_ID;
          endcase
        end
        ph_nxt = nx; frem_nxt = go_rem(nx);
        if (acc_nxt == 28'd0) begin
          pend = 1'b1; st = verdict(ph_nxt, err_nxt, kind_r, flags_r, frem_nxt);
          ph_nxt = FK_HEADER;
        end
      end
    end else begin
      idx = filt_r;
      fk = (ph_r == PH_FIRST_LEN) ? FK_TOPIC_LEN : ((ph_r > FK_SKIP) ? FK_SKIP : ph_r);
      br_nxt = br_r - 28'd1;
      if (is_word(ph_r)) begin
        if (frem_r != 16'd1) begin
          hold_nxt = b; frem_nxt = 16'd1;
        end else begin
          word = wtmp; wv = 1'b1;
          sp = (ph_r == PH_FIRST_LEN) ? FK_TOPIC : ph_r + 5'd1;
          if (ph_r == FK_KEEPALIVE || ph_r == FK_PKT_ID) begin
            nx = successor(ph_r, cfl_r, kind_r, flags_r);
            ph_nxt = nx; frem_nxt = go_rem(nx);
          end else if (wtmp == 16'd0 &&
                       (kind_r == T_SUBSCRIBE || kind_r == T_UNSUBSCRIBE)) begin
            err_nxt = 1'b1; ph_nxt = FK_SKIP; frem_nxt = go_rem(FK_SKIP);
          end else if (wtmp == 16'd0) begin
            nx = successor(sp, cfl_r, kind_r, flags_r);
            bump = bumps(sp, kind_r);
            ph_nxt = nx; frem_nxt = go_rem(nx);
          end else begin
            ph_nxt = sp; frem_nxt = wtmp;
          end
        end
      end else if (ph_r == FK_LEVEL || ph_r == FK_CFLAGS || ph_r == FK_QOS) begin
        if (ph_r == FK_CFLAGS) cfl_nxt = b;
        if (ph_r == FK_QOS) fb = {6'd0, b[1:0]};
        nx = successor(ph_r, cfl_r, kind_r, flags_r);
        bump = bumps(ph_r, kind_r);
        ph_nxt = nx; frem_nxt = go_rem(nx);
      end else if (ph_r == FK_PAYLOAD) begin
        ph_nxt = ph_r;
      end else if (ph_r == FK_NAME || ph_r == FK_CID || ph_r == FK_WT ||
                   ph_r == FK_WM || ph_r == FK_USER || ph_r == FK_PASS ||
                   ph_r == FK_TOPIC) begin
        frem_nxt = fdec;
        if (fdec == 16'd0) begin
          nx = successor(ph_r, cfl_r, kind_r, flags_r);
          bump = bumps(ph_r, kind_r);
          ph_nxt = nx; frem_nxt = go_rem(nx);
        end
      end else begin
        fk = FK_SKIP; err_nxt = 1'b1; ph_nxt = FK_SKIP;
      end
      if (bump) filt_nxt = filt_r + 8'd1;
      if (br_nxt == 28'd0) begin
        pend = 1'b1; st = verdict(ph_nxt, err_nxt, kind_nxt, flags_nxt, frem_nxt);
        ph_nxt = FK_HEADER;
      end
    end
  end

  // Advance parser state and load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= FK_HEADER; kind_r <= 4'd0; flags_r <= 4'd0; acc_r <= 28'd0;
      cnt_r <= 2'd0; br_r <= 28'd0; frem_r <= 16'd0; hold_r <= 8'd0;
      cfl_r <= 8'd0; filt_r <= 8'd0; err_r <= 1'b0; ovalid_r <= 1'b0;
    end else begin
      if (accept) begin
        ph_r <= ph_nxt; kind_r <= kind_nxt; flags_r <= flags_nxt; acc_r <= acc_nxt;
        cnt_r <= cnt_nxt; br_r <= br_nxt; frem_r <= frem_nxt; hold_r <= hold_nxt;
        cfl_r <= cfl_nxt; filt_r <= filt_nxt; err_r <= err_nxt;
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      odata_r <= {4'd0, st, br_nxt, acc_nxt, idx, wv, word, fb};
      ouser_r <= {fk, kind_nxt};
      olast_r <= pend;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

endmodule
